// File: hw/rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    // DEPTH: power of two, 8 .. 256
    localparam int DEPTH     = 256;
    localparam int MAX_XFER  = 8;
    localparam int NBANK     = 8;
    localparam int BANK_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = NBANK * BYTE_W;
    localparam int LVL_W     = 9;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = PTR_W + 1;
    localparam int ROW_W     = (PTR_W > BANK_W) ? PTR_W - BANK_W : 1;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef enum logic [1:0] {
        FN_PUT   = 2'd0,
        FN_GET   = 2'd1,
        FN_PEEK  = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [LEN_W-1:0]    length;
        logic [DATA_W-1:0]   put_data;
    } t_req;

    typedef struct packed {
        logic                status;
        logic [DATA_W-1:0]   read_data;
        logic [LVL_W-1:0]    fill_level;
        logic [LVL_W-1:0]    free_space;
        logic                full_out;
    } t_rsp;

    typedef struct packed {
        logic                issue;
        logic                wr_en;
        logic                rd_en;
        logic [PTR_W-1:0]    ptr;
        logic [NBANK-1:0]    lane_mask;
        logic [DATA_W-1:0]   wdata;
    } t_store_req;

endpackage

// File: hw/rtl/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/brb_store.sv
// ----------------------------------------------------------------------------
// brb_store
// Byte-banked store: eight byte-wide banks, bank from the low address bits,
// lane rotation on write and read.
// ----------------------------------------------------------------------------
module brb_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  brb_pkg::t_store_req       i_sreq,
    output logic [brb_pkg::DATA_W-1:0] o_rd_data
);
    import brb_pkg::*;

    logic [ROW_W-1:0]  bank_row   [NBANK];
    logic              bank_we    [NBANK];
    logic [BYTE_W-1:0] bank_wdata [NBANK];
    logic [BYTE_W-1:0] bank_rdata [NBANK];

    logic [BANK_W-1:0] r_base;
    logic [NBANK-1:0]  r_mask;

    always_comb begin
        logic [BANK_W-1:0] lane;
        logic [PTR_W-1:0]  addr;
        for (int b = 0; b < NBANK; b++) begin
            lane          = BANK_W'(b) - i_sreq.ptr[BANK_W-1:0];
            addr          = PTR_W'(i_sreq.ptr + PTR_W'(lane));
            bank_row[b]   = ROW_W'(addr >> BANK_W);
            bank_we[b]    = i_sreq.wr_en && i_sreq.lane_mask[lane];
            bank_wdata[b] = i_sreq.wdata[BYTE_W*lane +: BYTE_W];
        end
    end

    for (genvar g = 0; g < NBANK; g++) begin : g_bank
        brb_ram #(
            .ADDR_W (ROW_W),
            .DATA_W (BYTE_W)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (bank_we[g]),
            .i_rd_en   (i_sreq.rd_en),
            .i_addr    (bank_row[g]),
            .i_wr_data (bank_wdata[g]),
            .o_rd_data (bank_rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_sreq.issue) begin
            r_mask <= i_sreq.rd_en ? i_sreq.lane_mask : '0;
        end
        if (i_sreq.issue) begin
            r_base <= i_sreq.ptr[BANK_W-1:0];
        end
    end

    always_comb begin
        logic [BANK_W-1:0] bank;
        for (int i = 0; i < NBANK; i++) begin
            bank = BANK_W'(r_base + BANK_W'(i));
            o_rd_data[BYTE_W*i +: BYTE_W] = r_mask[i] ? bank_rdata[bank] : '0;
        end
    end

endmodule

// File: hw/rtl/byte_ring_buffer_bulk.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_bulk
// Circular byte FIFO with bulk put, get, peek and clear of up to eight bytes.
// ----------------------------------------------------------------------------
// The accept in S_IDLE writes the banks or issues the bank read and updates the
// pointers; S_READ then takes the registered bank data into the output register
// once that register is free. A new request is accepted only back in S_IDLE, so
// none is taken before the last result is registered; a stalled result holds it
// back only while the output register is still occupied. There is no clearing
// pass after reset; bytes are read only after they were written.
module byte_ring_buffer_bulk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  brb_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output brb_pkg::t_rsp o_rsp
);
    import brb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state            r_state;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic              r_full, n_full;
    t_rsp              r_pend, n_pend;
    t_rsp              r_out;
    logic              r_out_valid;

    t_store_req        sreq;
    logic [DATA_W-1:0] store_rdata;

    logic              accept;
    logic              len_ok;
    logic              put_go;
    logic              rd_go;
    logic [CNT_W-1:0]  held_cur, free_cur, held_nxt, len_c;

    always_comb begin
        accept   = i_valid && (r_state == S_IDLE);
        len_ok   = i_req.length <= LEN_W'(MAX_XFER);
        len_c    = CNT_W'(i_req.length);
        held_cur = r_full ? CNT_W'(DEPTH) : {1'b0, r_wr_ptr - r_rd_ptr};
        free_cur = CNT_W'(DEPTH) - held_cur;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_full   = r_full;
        put_go   = 1'b0;
        rd_go    = 1'b0;
        n_pend   = '0;
        n_pend.status = ST_DONE;

        unique case (i_req.func)
            FN_CLEAR: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
                n_full   = 1'b0;
            end
            FN_PUT: begin
                if (!len_ok || len_c > free_cur) begin
                    n_pend.status = ST_REFUSED;
                end else if (i_req.length != '0) begin
                    put_go   = 1'b1;
                    n_wr_ptr = PTR_W'(r_wr_ptr + PTR_W'(i_req.length));
                    n_full   = (n_wr_ptr == r_rd_ptr);
                end
            end
            FN_GET, FN_PEEK: begin
                if (!len_ok || len_c > held_cur) begin
                    n_pend.status = ST_REFUSED;
                end else begin
                    rd_go = 1'b1;
                    if (i_req.func == FN_GET && i_req.length != '0) begin
                        n_rd_ptr = PTR_W'(r_rd_ptr + PTR_W'(i_req.length));
                        n_full   = 1'b0;
                    end
                end
            end
            default: begin
                n_pend.status = ST_REFUSED;
            end
        endcase

        held_nxt          = n_full ? CNT_W'(DEPTH) : {1'b0, n_wr_ptr - n_rd_ptr};
        n_pend.fill_level = LVL_W'(held_nxt);
        n_pend.free_space = LVL_W'(CNT_W'(DEPTH) - held_nxt);
        n_pend.full_out   = n_full;

        sreq.issue     = accept;
        sreq.wr_en     = accept && put_go;
        sreq.rd_en     = accept && rd_go;
        sreq.ptr       = (i_req.func == FN_PUT) ? r_wr_ptr : r_rd_ptr;
        sreq.lane_mask = NBANK'((16'd1 << i_req.length) - 16'd1);
        sreq.wdata     = i_req.put_data;
    end

    brb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sreq    (sreq),
        .o_rd_data (store_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_READ && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pend   <= n_pend;
                        r_wr_ptr <= n_wr_ptr;
                        r_rd_ptr <= n_rd_ptr;
                        r_full   <= n_full;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out   <= {r_pend.status, store_rdata, r_pend.fill_level,
                                    r_pend.free_space, r_pend.full_out};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// File: hw/rtl/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks of the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module brb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          o_stall,
    input  logic          o_valid,
    input  logic          i_stall,
    input  brb_pkg::t_rsp o_rsp
);
    import brb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("stalled result changed");

    a_level_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> LVL_W'(o_rsp.fill_level + o_rsp.free_space) == LVL_W'(DEPTH))
        else $error("fill level and free space disagree");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.full_out |->
            o_rsp.fill_level == LVL_W'(DEPTH) && o_rsp.free_space == '0)
        else $error("full flag without full level");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status == ST_REFUSED |-> o_rsp.read_data == '0)
        else $error("refused request returned data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while previous one in flight");

endmodule

bind byte_ring_buffer_bulk brb_checker u_brb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// File: tb/byte_ring_buffer_bulk_tb.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_bulk_tb
// Self-checking bench for the bulk byte ring buffer. A clocked driver sends
// put, get, peek and clear requests in bursts, the receiver stalls on a
// rotating pattern, and each result is compared field by field against a
// cycle-free ring model kept in the bench.
// ----------------------------------------------------------------------------
module byte_ring_buffer_bulk_tb;
    import brb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 600;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    t_req          i_req   = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    t_rsp          o_rsp;

    byte_ring_buffer_bulk dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req             pending_reqs[$];
    t_rsp             rsp_expect_q[$];
    int               plan_level  = 0;
    int               mismatch_cnt = 0;
    logic [31:0]      cycle_cnt   = '0;
    logic             req_taken   = 1'b0;
    int               gap_left    = 0;
    int               burst_left  = 1;

    // ring model state
    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    logic [PTR_W-1:0]  wr_ptr    = '0;
    logic [PTR_W-1:0]  rd_ptr    = '0;
    logic              ring_full = 1'b0;

    function automatic logic [LVL_W-1:0] ring_level();
        if (ring_full) begin
            return LVL_W'(DEPTH);
        end
        return LVL_W'(PTR_W'(wr_ptr - rd_ptr));
    endfunction

    function automatic t_rsp ring_apply(t_req r);
        t_rsp             rsp;
        logic [LVL_W-1:0] held;
        rsp  = '0;
        held = ring_level();
        if (r.func == FN_CLEAR) begin
            wr_ptr    = '0;
            rd_ptr    = '0;
            ring_full = 1'b0;
        end else if (r.length > MAX_XFER) begin
            rsp.status = ST_REFUSED;
        end else if (r.func == FN_PUT) begin
            if (r.length > DEPTH - held) begin
                rsp.status = ST_REFUSED;
            end else if (r.length != 0) begin
                for (int i = 0; i < r.length; i++) begin
                    ring_bytes[wr_ptr + PTR_W'(i)] = r.put_data[BYTE_W*i +: BYTE_W];
                end
                wr_ptr    = wr_ptr + PTR_W'(r.length);
                ring_full = (wr_ptr == rd_ptr);
            end
        end else begin
            if (r.length > held) begin
                rsp.status = ST_REFUSED;
            end else begin
                for (int i = 0; i < r.length; i++) begin
                    rsp.read_data[BYTE_W*i +: BYTE_W] = ring_bytes[rd_ptr + PTR_W'(i)];
                end
                if (r.func == FN_GET && r.length != 0) begin
                    rd_ptr    = rd_ptr + PTR_W'(r.length);
                    ring_full = 1'b0;
                end
            end
        end
        held           = ring_level();
        rsp.fill_level = held;
        rsp.free_space = LVL_W'(DEPTH) - held;
        rsp.full_out   = ring_full;
        return rsp;
    endfunction

    task automatic flag_error(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("ERROR @%0d: %s", cycle_cnt, msg);
        end
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want_v,
                               logic [DATA_W-1:0] got_v);
        if (got_v !== want_v) begin
            flag_error($sformatf("%s expected %h got %h", name, want_v, got_v));
        end
    endtask

    // request stream; keeps a rough fill estimate to steer the sequences
    task automatic queue_req(t_func f, int len, logic [DATA_W-1:0] data);
        t_req r;
        r.func     = f;
        r.length   = LEN_W'(len);
        r.put_data = data;
        pending_reqs.push_back(r);
        if (f == FN_CLEAR) begin
            plan_level = 0;
        end else if (len <= MAX_XFER) begin
            if (f == FN_PUT && len <= DEPTH - plan_level) begin
                plan_level += len;
            end else if (f == FN_GET && len <= plan_level) begin
                plan_level -= len;
            end
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_bytes();
        return {$urandom, $urandom};
    endfunction

    function automatic t_func rand_func(int hi);
        return t_func'(2'($urandom_range(0, hi)));
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("byte_ring_buffer_bulk regression: fail");
            $finish;
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_rsp want;
        req_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (rsp_expect_q.size() == 0) begin
                    flag_error("result with no request outstanding");
                end else begin
                    want = rsp_expect_q.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(o_rsp.status));
                    check_field("read_data", want.read_data, o_rsp.read_data);
                    check_field("fill_level", DATA_W'(want.fill_level),
                                DATA_W'(o_rsp.fill_level));
                    check_field("free_space", DATA_W'(want.free_space),
                                DATA_W'(o_rsp.free_space));
                    check_field("full_out", DATA_W'(want.full_out), DATA_W'(o_rsp.full_out));
                end
            end
            if (i_valid && !o_stall) begin
                rsp_expect_q.push_back(ring_apply(i_req));
            end
        end
    end

    // driver and receiver stall
    always @(negedge i_clk) begin
        case (cycle_cnt[10:8])
            3'd0, 3'd1: i_stall <= 1'b0;
            3'd2:       i_stall <= ($urandom_range(0, 3) == 0);
            3'd3:       i_stall <= 1'(8'b0110_0011 >> cycle_cnt[2:0]);
            3'd4:       i_stall <= ($urandom_range(0, 3) != 0);
            default:    i_stall <= 1'($urandom_range(0, 1));
        endcase

        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_taken) begin
            // held while stalled
        end else if (gap_left > 0) begin
            i_valid  <= 1'b0;
            gap_left = gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
            i_valid <= 1'b1;
            i_req   <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
                burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    initial begin
        int kind;
        int len;
        int w;

        // directed
        queue_req(FN_GET,   1,  rand_bytes());
        queue_req(FN_PEEK,  0,  rand_bytes());
        queue_req(FN_PUT,   0,  rand_bytes());
        queue_req(FN_PUT,   9,  rand_bytes());
        queue_req(FN_PUT,   15, '1);
        queue_req(FN_PUT,   8,  '1);
        queue_req(FN_PEEK,  8,  '0);
        queue_req(FN_GET,   0,  '0);
        queue_req(FN_GET,   8,  '0);
        queue_req(FN_PUT,   8,  '0);
        queue_req(FN_PUT,   3,  64'h0123_4567_89ab_cdef);
        queue_req(FN_PEEK,  9,  '0);
        queue_req(FN_GET,   15, '0);
        queue_req(FN_GET,   5,  '0);
        queue_req(FN_PEEK,  6,  '0);
        queue_req(FN_CLEAR, 15, '1);
        queue_req(FN_GET,   1,  '0);
        queue_req(FN_PUT,   5,  64'hfedc_ba98_7654_3210);
        queue_req(FN_CLEAR, 0,  '0);
        queue_req(FN_PUT,   8,  64'h0123_4567_89ab_cdef);
        queue_req(FN_GET,   8,  '1);

        while (pending_reqs.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                while (plan_level < DEPTH) begin
                    len = $urandom_range(1, MAX_XFER);
                    if (len > DEPTH - plan_level) begin
                        len = DEPTH - plan_level;
                    end
                    queue_req(FN_PUT, len, rand_bytes());
                    if ($urandom_range(0, 7) == 0) begin
                        queue_req(FN_PEEK, $urandom_range(0, MAX_XFER), rand_bytes());
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    queue_req(rand_func(2), $urandom_range(0, 15), rand_bytes());
                end
            end else if (kind < 6) begin
                while (plan_level > 0) begin
                    len = $urandom_range(1, MAX_XFER);
                    if (len > plan_level) begin
                        len = plan_level;
                    end
                    queue_req(FN_GET, len, rand_bytes());
                    if ($urandom_range(0, 7) == 0) begin
                        queue_req(FN_PEEK, $urandom_range(0, MAX_XFER), rand_bytes());
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    queue_req(rand_func(2), $urandom_range(0, 15), rand_bytes());
                end
            end else if (kind == 6) begin
                queue_req(FN_CLEAR, $urandom_range(0, 15), rand_bytes());
            end else begin
                repeat ($urandom_range(10, 40)) begin
                    w   = $urandom_range(0, 31);
                    len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, MAX_XFER);
                    if (w < 13) begin
                        queue_req(FN_PUT, len, rand_bytes());
                    end else if (w < 23) begin
                        queue_req(FN_GET, len, rand_bytes());
                    end else if (w < 31) begin
                        queue_req(FN_PEEK, len, rand_bytes());
                    end else begin
                        queue_req(FN_CLEAR, len, rand_bytes());
                    end
                end
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid || rsp_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (rsp_expect_q.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", rsp_expect_q.size()));
        end

        if (mismatch_cnt == 0) begin
            $display("byte_ring_buffer_bulk regression: pass");
        end else begin
            $display("byte_ring_buffer_bulk regression: fail");
        end
        $finish;
    end

endmodule
